>>> hdl/adcm_pkg.sv
// Shared types, command codes and field-edit helper for the two-wire ADC master.
package adcm_pkg;

  // Sequencer phase of one transfer.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // Request kinds.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_CFG    = 2'd2;
  localparam logic [1:0] KIND_WRITE  = 2'd3;

  // Configuration byte fields.
  localparam logic [1:0] FIELD_CHANNEL = 2'd0;
  localparam logic [1:0] FIELD_GAIN    = 2'd1;
  localparam logic [1:0] FIELD_RATE    = 2'd2;
  localparam logic [1:0] FIELD_REF     = 2'd3;

  // Channel code that is reserved and leaves the field cleared.
  localparam logic [1:0] CHANNEL_RESERVED = 2'd1;

  // Reference codes that clear or set the reference bit; the other codes keep it.
  localparam logic [1:0] REF_CLEAR = 2'd0;
  localparam logic [1:0] REF_SET   = 2'd1;

  // Seven-bit commands sent MSB first.
  localparam logic [6:0] CMD_READ  = 7'h56;
  localparam logic [6:0] CMD_WRITE = 7'h65;

  localparam logic [7:0] MASK_CHANNEL = 8'hFC;
  localparam logic [7:0] MASK_GAIN    = 8'hF3;
  localparam logic [7:0] MASK_RATE    = 8'hCF;
  localparam logic [7:0] MASK_REF     = 8'hBF;
  localparam logic [7:0] BIT_REF      = 8'h40;

  localparam logic [7:0] SCK_HALF_RESET = 8'd8;

  // One input request.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field_select;
    logic [1:0] field_value;
    logic       dout_level;
  } item_t;

  // One result.
  typedef struct packed {
    logic        sck_level;
    logic        sda_drive;
    logic        sda_level;
    logic        busy_res;
    logic        sample_valid;
    logic [23:0] sample_value;
    logic        config_valid;
    logic [7:0]  config_value;
  } result_t;

  // Rewrites one field of the configuration byte.
  function automatic logic [7:0] edit_field(input logic [7:0] v, input logic [1:0] fsel,
                                            input logic [1:0] code);
    logic [7:0] r;
    r = v;
    case (fsel)
      FIELD_CHANNEL: begin
        r = v & MASK_CHANNEL;
        if (code != CHANNEL_RESERVED) r = r | {6'd0, code};
      end
      FIELD_GAIN: r = (v & MASK_GAIN) | {4'd0, code, 2'd0};
      FIELD_RATE: r = (v & MASK_RATE) | {2'd0, code, 4'd0};
      default: begin
        if (code == REF_CLEAR) r = v & MASK_REF;
        else if (code == REF_SET) r = v | BIT_REF;
      end
    endcase
    return r;
  endfunction

endpackage

>>> hdl/adc_two_wire_sample_and_config_master.sv
// Top level of the two-wire ADC master: request register, sequencer, result register.
//
// This block is a tick-level master for a two-wire delta-sigma converter whose single
// data pin also signals data-ready. Each request on the slave stream is one clock tick:
// it carries a command kind and the sampled pin level, and produces exactly one result
// with the serial clock level, the data-pin drive and level, a busy flag and any sample
// or configuration byte that completed on that tick. A transfer waits for the pin to
// read low, then runs clock pulses whose high and low phases last sck_half_period ticks
// each (zero acts as one). A sample read returns SAMPLE_BITS bits right-aligned in 24;
// a configuration read returns one byte; a field write reads the byte, edits one field
// and writes it back, reporting the byte it read. Start commands that arrive while a
// transfer runs are dropped. One request is accepted every clock cycle while the master
// side does not stall; the sequencer's step logic moves each request from the request
// register into the result register, which presents its result on the master side.
// A stall on the master side holds the result register and, once the request register
// is full, back-pressures the slave side in the same cycle. The half-period register
// may be written at any time the block is idle and is always ready.
module adc_two_wire_sample_and_config_master #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] field_select, [3:2] field_value, [4] dout_level
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] sck_level, [1] sda_drive, [2] sda_level,
                                 // [3] busy_res, [27:4] sample_value, [35:28] config_value
  output logic [1:0]  m_tuser,   // [0] sample_valid, [1] config_valid
  // Half-period register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                in_valid;
  adcm_pkg::item_t     in_item;
  logic                advance;
  logic                step;
  logic [7:0]          sck_half_period;
  adcm_pkg::result_t   step_res;
  adcm_pkg::result_t   out_res;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance  = !m_tvalid || m_tready;
  assign step     = advance && in_valid;
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind         <= s_tuser;
      in_item.field_select <= s_tdata[1:0];
      in_item.field_value  <= s_tdata[3:2];
      in_item.dout_level   <= s_tdata[4];
    end
  end

  // Half-period configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sck_half_period <= adcm_pkg::SCK_HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sck_half_period <= cfg_data;
    end
  end

  adcm_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_item),
    .half_period (sck_half_period),
    .res         (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {4'd0, out_res.config_value, out_res.sample_value, out_res.busy_res,
                    out_res.sda_level, out_res.sda_drive, out_res.sck_level};
  assign m_tuser = {out_res.config_valid, out_res.sample_valid};

`ifndef SYNTHESIS
  // A tick never completes both a sample read and a configuration read.
  a_one_completion: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.sample_valid && out_res.config_valid))
    else $error("sample and config completion on the same tick");

  // A finished sample read always returns the sequencer to idle.
  a_sample_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.sample_valid) |-> !out_res.busy_res)
    else $error("busy after sample completion");

  // When idle the clock is low and the data pin is released.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.busy_res) |-> (!out_res.sck_level && !out_res.sda_drive))
    else $error("pins active while idle");

  // A result taken by the sink always frees room for a new request.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("request side stalled while result side is ready");
`endif

endmodule

>>> hdl/adcm_seq.sv
// Pin-level sequencer: transfer state and the single-pass step logic for one tick.
module adcm_seq #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  adcm_pkg::item_t     item,
  input  logic [7:0]          half_period,
  output adcm_pkg::result_t   res
);

  localparam logic [5:0] BASE         = 6'(SAMPLE_BITS + 3);
  localparam logic [5:0] PC_RD_FIRST  = 6'(SAMPLE_BITS + 14);
  localparam logic [5:0] PC_RD_LAST   = 6'(SAMPLE_BITS + 21);
  localparam logic [5:0] PC_CFG_END   = 6'(SAMPLE_BITS + 22);
  localparam logic [5:0] SB6          = 6'(SAMPLE_BITS);

  adcm_pkg::phase_t         phase, phase_next;
  logic [5:0]               pulse_count, pulse_count_next;
  logic [7:0]               phase_timer, phase_timer_next;
  logic [SAMPLE_BITS-1:0]   sample_shift, sample_shift_next;
  logic [7:0]               config_shift, config_shift_next;
  logic [1:0]               pending_field, pending_field_next;
  logic [1:0]               pending_value, pending_value_next;
  logic                     write_after_read, write_after_read_next;
  logic [1:0]               xfer_kind, xfer_kind_next;
  logic                     clock_out, clock_out_next;
  logic                     data_drive, data_drive_next;
  logic                     data_out, data_out_next;

  logic                     reading;
  logic [7:0]               half;
  logic [7:0]               timer_inc;
  logic [5:0]               pc_inc;
  logic [5:0]               rel;
  logic [5:0]               cmd_idx;
  logic [5:0]               dat_idx;
  logic [6:0]               cmd;
  logic                     bp_drive, bp_out;
  logic                     s_valid, c_valid;
  logic [SAMPLE_BITS-1:0]   s_val;
  logic [7:0]               c_val;

  assign reading   = (xfer_kind == adcm_pkg::KIND_CFG) ||
                     (xfer_kind == adcm_pkg::KIND_WRITE && write_after_read);
  assign half      = (half_period == 8'd0) ? 8'd1 : half_period;
  assign timer_inc = phase_timer + 8'd1;
  assign pc_inc    = pulse_count + 6'd1;
  assign rel       = pc_inc - BASE;
  assign cmd_idx   = 6'd9 - rel;
  assign dat_idx   = 6'd18 - rel;
  assign cmd       = reading ? adcm_pkg::CMD_READ : adcm_pkg::CMD_WRITE;

  // Pin drive for the pulse that would start this tick.
  always_comb begin
    bp_drive = data_drive;
    bp_out   = data_out;
    if (xfer_kind != adcm_pkg::KIND_SAMPLE && pc_inc > BASE) begin
      if (rel == 6'd1) begin
        bp_drive = 1'b1;
        bp_out   = 1'b0;
      end else if (rel >= 6'd3 && rel <= 6'd9) begin
        bp_out = cmd[cmd_idx[2:0]];
      end else if (rel >= 6'd11 && rel <= 6'd18) begin
        if (reading) begin
          bp_drive = 1'b0;
          bp_out   = 1'b0;
        end else begin
          bp_out = config_shift[dat_idx[2:0]];
        end
      end
    end
  end

  always_comb begin
    phase_next            = phase;
    pulse_count_next      = pulse_count;
    phase_timer_next      = phase_timer;
    sample_shift_next     = sample_shift;
    config_shift_next     = config_shift;
    pending_field_next    = pending_field;
    pending_value_next    = pending_value;
    write_after_read_next = write_after_read;
    xfer_kind_next        = xfer_kind;
    clock_out_next        = clock_out;
    data_drive_next       = data_drive;
    data_out_next         = data_out;
    s_valid               = 1'b0;
    c_valid               = 1'b0;
    s_val                 = '0;
    c_val                 = '0;
    unique case (phase)
      adcm_pkg::PH_IDLE: begin
        if (item.kind != adcm_pkg::KIND_TICK) begin
          xfer_kind_next        = item.kind;
          pending_field_next    = item.field_select;
          pending_value_next    = item.field_value;
          write_after_read_next = (item.kind == adcm_pkg::KIND_WRITE);
          sample_shift_next     = '0;
          config_shift_next     = '0;
          pulse_count_next      = '0;
          phase_timer_next      = '0;
          phase_next            = adcm_pkg::PH_WAIT;
        end
      end
      adcm_pkg::PH_WAIT: begin
        if (!item.dout_level) begin
          pulse_count_next = pc_inc;
          clock_out_next   = 1'b1;
          phase_timer_next = '0;
          data_drive_next  = bp_drive;
          data_out_next    = bp_out;
          phase_next       = adcm_pkg::PH_HIGH;
        end
      end
      adcm_pkg::PH_HIGH: begin
        phase_timer_next = timer_inc;
        if (timer_inc >= half) begin
          // Config bits are taken on the falling-edge tick.
          if (reading && pulse_count >= PC_RD_FIRST && pulse_count <= PC_RD_LAST)
            config_shift_next = {config_shift[6:0], item.dout_level};
          clock_out_next   = 1'b0;
          phase_timer_next = '0;
          phase_next       = adcm_pkg::PH_LOW;
        end
      end
      adcm_pkg::PH_LOW: begin
        phase_timer_next = timer_inc;
        // Sample bits are taken on the first tick of the low phase, after the falling edge.
        if (timer_inc == 8'd1 && pulse_count >= 6'd1 && pulse_count <= SB6)
          sample_shift_next = {sample_shift[SAMPLE_BITS-2:0], item.dout_level};
        if (timer_inc >= half) begin
          if (pulse_count < ((xfer_kind == adcm_pkg::KIND_SAMPLE) ? BASE : PC_CFG_END)) begin
            pulse_count_next = pc_inc;
            clock_out_next   = 1'b1;
            phase_timer_next = '0;
            data_drive_next  = bp_drive;
            data_out_next    = bp_out;
            phase_next       = adcm_pkg::PH_HIGH;
          end else if (xfer_kind == adcm_pkg::KIND_SAMPLE) begin
            s_valid          = 1'b1;
            s_val            = sample_shift_next;
            phase_next       = adcm_pkg::PH_IDLE;
            pulse_count_next = '0;
            phase_timer_next = '0;
          end else if (reading) begin
            c_valid          = 1'b1;
            c_val            = config_shift;
            pulse_count_next = '0;
            phase_timer_next = '0;
            if (write_after_read) begin
              config_shift_next = adcm_pkg::edit_field(config_shift, pending_field,
                                                       pending_value);
              write_after_read_next = 1'b0;
              sample_shift_next     = '0;
              phase_next            = adcm_pkg::PH_WAIT;
            end else begin
              phase_next = adcm_pkg::PH_IDLE;
            end
          end else begin
            data_drive_next  = 1'b0;
            data_out_next    = 1'b0;
            phase_next       = adcm_pkg::PH_IDLE;
            pulse_count_next = '0;
            phase_timer_next = '0;
          end
        end
      end
      default: phase_next = adcm_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    res.sck_level    = clock_out_next;
    res.sda_drive    = data_drive_next;
    res.sda_level    = data_out_next;
    res.busy_res     = (phase_next != adcm_pkg::PH_IDLE);
    res.sample_valid = s_valid;
    res.sample_value = 24'(s_val);
    res.config_valid = c_valid;
    res.config_value = c_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= adcm_pkg::PH_IDLE;
      pulse_count      <= '0;
      phase_timer      <= '0;
      sample_shift     <= '0;
      config_shift     <= '0;
      pending_field    <= '0;
      pending_value    <= '0;
      write_after_read <= 1'b0;
      xfer_kind        <= adcm_pkg::KIND_TICK;
      clock_out        <= 1'b0;
      data_drive       <= 1'b0;
      data_out         <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      pulse_count      <= pulse_count_next;
      phase_timer      <= phase_timer_next;
      sample_shift     <= sample_shift_next;
      config_shift     <= config_shift_next;
      pending_field    <= pending_field_next;
      pending_value    <= pending_value_next;
      write_after_read <= write_after_read_next;
      xfer_kind        <= xfer_kind_next;
      clock_out        <= clock_out_next;
      data_drive       <= data_drive_next;
      data_out         <= data_out_next;
    end
  end

endmodule
